/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: store geometry,
// operation codes and the input and result word layouts.
// ----------------------------------------------------------------------------
package deq_pkg;

  // store geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [6:0]            out_cnt_t;

  // operation codes
  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_t;

  // input word
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] popped_value;
    logic        underflow;
    logic        overflow_dropped;
    out_cnt_t    count;
    logic        is_empty;
  } out_word_t;

  // operation in flight while the store read completes
  typedef struct packed {
    logic     rd;
    logic     underflow;
    logic     overflow_dropped;
    out_cnt_t count;
    logic     is_empty;
  } pend_t;

  // circular index steps
  function automatic idx_t idx_next(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

/* rtl/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Read data holds when not reading.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque in a circular RAM with push/pop at either end.
// ----------------------------------------------------------------------------
// Each input word is one operation: push back, push front, pop back or pop
// front. At acceptance the pointers and count update, the RAM is written or
// read and the operation enters the pending stage; the result is then formed
// from the RAM read data into an output register. The RAM's single write and
// single read port allow one word per cycle in steady state; a stalled output
// holds the pipeline after one more word. A pop on an empty queue returns zero
// with underflow set; a push on a full queue is dropped with overflow_dropped
// set. Every result carries the element count after the operation and an empty
// flag.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output deq_pkg::out_word_t out_word
);

  deq_pkg::idx_t  front_r, front_nxt;
  deq_pkg::idx_t  back_r, back_nxt;
  deq_pkg::cnt_t  count_r, count_nxt;

  logic               pend_v_r;
  deq_pkg::pend_t     pend_r, pend_nxt;
  logic               out_v_r;
  deq_pkg::out_word_t out_r;

  logic               out_free, pend_free, accept;
  logic               wr_en, rd_en;
  deq_pkg::idx_t      wr_addr, rd_addr;
  deq_pkg::data_t     rd_data;
  logic               full, empty;

  // flow control between stages
  assign out_free  = !out_v_r || !out_stall;
  assign pend_free = !pend_v_r || out_free;
  assign in_stall  = !pend_free;
  assign accept    = in_valid && pend_free;

  assign full  = (count_r == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign empty = (count_r == '0);

  // operation decode, pointer and count update
  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = back_r;
    rd_addr   = front_r;
    pend_nxt  = '0;
    unique case (in_word.kind)
      deq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          pend_nxt.overflow_dropped = 1'b1;
        end else begin
          wr_en     = accept;
          wr_addr   = back_r;
          back_nxt  = deq_pkg::idx_next(back_r);
          count_nxt = deq_pkg::cnt_t'(count_r + deq_pkg::cnt_t'(1));
        end
      end
      deq_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          pend_nxt.overflow_dropped = 1'b1;
        end else begin
          wr_en     = accept;
          front_nxt = deq_pkg::idx_prev(front_r);
          wr_addr   = front_nxt;
          count_nxt = deq_pkg::cnt_t'(count_r + deq_pkg::cnt_t'(1));
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          pend_nxt.underflow = 1'b1;
        end else begin
          rd_en       = accept;
          pend_nxt.rd = 1'b1;
          back_nxt    = deq_pkg::idx_prev(back_r);
          rd_addr     = back_nxt;
          count_nxt   = deq_pkg::cnt_t'(count_r - deq_pkg::cnt_t'(1));
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          pend_nxt.underflow = 1'b1;
        end else begin
          rd_en       = accept;
          pend_nxt.rd = 1'b1;
          rd_addr     = front_r;
          front_nxt   = deq_pkg::idx_next(front_r);
          count_nxt   = deq_pkg::cnt_t'(count_r - deq_pkg::cnt_t'(1));
        end
      end
      default: begin
      end
    endcase
    pend_nxt.count    = deq_pkg::out_cnt_t'(count_nxt);
    pend_nxt.is_empty = (count_nxt == '0);
  end

  // element store
  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (deq_pkg::data_t'(in_word.value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // pending stage waiting on read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (pend_free) begin
      pend_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= pend_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_v_r) begin
      out_r.popped_value     <= pend_r.rd ? 32'(rd_data) : 32'd0;
      out_r.underflow        <= pend_r.underflow;
      out_r.overflow_dropped <= pend_r.overflow_dropped;
      out_r.count            <= pend_r.count;
      out_r.is_empty         <= pend_r.is_empty;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule
